[rtl/midi_event_tracker_assert.svh]
// assertion macros used by the midi event tracker top level
`ifndef MIDI_EVENT_TRACKER_ASSERT_SVH
`define MIDI_EVENT_TRACKER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define MET_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define MET_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define MET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/met_pkg.sv]
// shared types and constants for the midi event tracker
`default_nettype none

package met_pkg;

    localparam int MET_MAX_EVENTS = 12;
    localparam logic [4:0] MET_CPM_RESET = 5'd6;

    // channel message types (status high nibble)
    localparam logic [3:0] T_NOTE_OFF   = 4'h8;
    localparam logic [3:0] T_NOTE_ON    = 4'h9;
    localparam logic [3:0] T_CTRL       = 4'hB;
    localparam logic [3:0] T_PROGRAM    = 4'hC;
    localparam logic [3:0] T_CHAN_PRESS = 4'hD;
    localparam logic [3:0] T_BEND       = 4'hE;

    typedef struct packed {
        logic [31:0] stamp;
        logic [3:0]  msg_type;
        logic [3:0]  chan;
        logic [7:0]  d1;
        logic [7:0]  d2;
    } met_entry_t;

    typedef struct packed {
        logic tok_shift;
        logic tok_clr;
        logic ins;
        logic upd;
    } met_cell_ctl_t;

    typedef struct packed {
        logic head;
        logic hit;
        logic cond;
    } met_flags_t;

    typedef struct packed {
        logic       tick;
        logic       mark;
        logic       msg_done;
        logic [3:0] msg_type;
        logic [3:0] chan;
        logic [7:0] d1;
        logic [7:0] d2;
    } met_parse_t;

endpackage

`default_nettype wire

[rtl/midi_event_tracker.sv]
// midi event tracker top level: parser, cell chain, sequencer, output register
//
//  channel | signals                              | beat when
//  --------+--------------------------------------+----------------------------
//  in      | in_valid in_ready op midi_byte now   | in_valid && in_ready
//  out     | out_valid out_ready report_kind ...  | out_valid && out_ready
//  cfg     | cfg_we cfg_wdata                     | cfg_we
//
// ticks, clock bytes with no mark, status and first data bytes complete while idle
// a clock mark, or a message into an empty list, goes straight to the commit step
// any other completed message has one probe of the newest cell, then for a note-off
//   with no note-on of that note there, a search that walks a token one cell per cycle,
//   then a commit step that shifts or rewrites the chain
// the result sits in an output register; the next beat is taken meanwhile,
//   and a later result waits in the commit step until that register frees
// no clearing pass after reset: cells past entry_count are never examined
`default_nettype none
`include "midi_event_tracker_assert.svh"

module midi_event_tracker
    import met_pkg::*;
#(
    parameter int MAX_EVENTS = MET_MAX_EVENTS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [7:0]  midi_byte,
    input  wire logic [31:0] now,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       report_kind,
    output logic [3:0]       slot,
    output logic [3:0]       msg_type,
    output logic [3:0]       channel,
    output logic [7:0]       first_data,
    output logic [7:0]       second_data,
    output logic [31:0]      stamp,
    output logic [31:0]      clock_time,
    output logic [3:0]       entry_count
);

    localparam int CNT_W = $clog2(MAX_EVENTS + 1);
    localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PROBE  = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    // pending actions
    localparam logic [1:0] ACT_INS  = 2'd0;
    localparam logic [1:0] ACT_UPD  = 2'd1;
    localparam logic [1:0] ACT_MARK = 2'd2;

    // report kinds
    localparam logic [1:0] RK_INSERT = 2'd0;
    localparam logic [1:0] RK_UPDATE = 2'd1;
    localparam logic [1:0] RK_MARK   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       act_reg, act_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      timer_reg, timer_next;
    logic [31:0]      mark_time_reg, mark_time_next;
    logic [3:0]       msg_type_reg, msg_type_next;
    logic [3:0]       chan_reg, chan_next;
    logic [7:0]       d1_reg, d1_next;
    logic [7:0]       d2_reg, d2_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic [3:0]       slot_reg, slot_next;
    logic [3:0]       otype_reg, otype_next;
    logic [3:0]       ochan_reg, ochan_next;
    logic [7:0]       od1_reg, od1_next;
    logic [7:0]       od2_reg, od2_next;
    logic [31:0]      ostamp_reg, ostamp_next;
    logic [31:0]      otime_reg, otime_next;
    logic [3:0]       ocount_reg, ocount_next;

    logic             accept;
    logic             out_free;
    logic             inject;
    logic             any_head, any_hit, any_cond;
    logic             last_idx;
    logic [CNT_W-1:0] count_ins;
    met_parse_t       pr;
    met_cell_ctl_t    ctl;
    met_entry_t       key;

    met_entry_t       ent_chain [MAX_EVENTS];
    met_flags_t       flg       [MAX_EVENTS];
    logic [MAX_EVENTS-1:0] tok_vec;
    logic [MAX_EVENTS-1:0] head_vec, hit_vec, cond_vec;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign inject   = accept && pr.msg_done && (count_reg != '0);

    // new entry as written into a cell, stamped with the current timer
    assign key.stamp    = timer_reg;
    assign key.msg_type = msg_type_reg;
    assign key.chan     = chan_reg;
    assign key.d1       = d1_reg;
    assign key.d2       = d2_reg;

    // at most one cell holds the token, so the flags just or together
    assign any_head = |head_vec;
    assign any_hit  = |hit_vec;
    assign any_cond = |cond_vec;

    assign last_idx  = CNT_W'(idx_reg) == (count_reg - CNT_W'(1));
    // full list drops its oldest entry, so the count saturates
    assign count_ins = (count_reg == CNT_W'(MAX_EVENTS)) ? count_reg
                                                         : count_reg + CNT_W'(1);

    met_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .op        (op),
        .midi_byte (midi_byte),
        .result    (pr)
    );

    // cell 0 takes the new entry and the injected token; each later cell
    // takes its left neighbor's entry and token
    assign ent_chain[0] = key;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_EVENTS; gi++)
        begin : g_cell
            if (gi < MAX_EVENTS - 1)
            begin : g_mid
                met_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctl       (ctl),
                    .key       (key),
                    .entry_in  (ent_chain[gi]),
                    .tok_in    ((gi == 0) ? inject : tok_vec[(gi == 0) ? 0 : gi - 1]),
                    .entry_out (ent_chain[gi + 1]),
                    .tok_out   (tok_vec[gi]),
                    .flags     (flg[gi])
                );
            end
            else
            begin : g_last
                met_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctl       (ctl),
                    .key       (key),
                    .entry_in  (ent_chain[gi]),
                    .tok_in    ((gi == 0) ? inject : tok_vec[(gi == 0) ? 0 : gi - 1]),
                    .entry_out (),
                    .tok_out   (tok_vec[gi]),
                    .flags     (flg[gi])
                );
            end
            assign head_vec[gi] = flg[gi].head;
            assign hit_vec[gi]  = flg[gi].hit;
            assign cond_vec[gi] = flg[gi].cond;
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        timer_next     = timer_reg;
        mark_time_next = mark_time_reg;
        msg_type_next  = msg_type_reg;
        chan_next      = chan_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        ctl            = '0;

        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        otype_next     = otype_reg;
        ochan_next     = ochan_reg;
        od1_next       = od1_reg;
        od2_next       = od2_reg;
        ostamp_next    = ostamp_reg;
        otime_next     = otime_reg;
        ocount_next    = ocount_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // shifting here moves the injected token into cell 0
                ctl.tok_shift = 1'b1;
                if (accept)
                begin
                    idx_next = '0;
                    if (pr.tick)
                    begin
                        timer_next = timer_reg + 32'd1;
                    end
                    else if (pr.mark)
                    begin
                        act_next       = ACT_MARK;
                        mark_time_next = now;
                        state_next     = ST_COMMIT;
                    end
                    else if (pr.msg_done)
                    begin
                        msg_type_next = pr.msg_type;
                        chan_next     = pr.chan;
                        d1_next       = pr.d1;
                        d2_next       = pr.d2;
                        if (count_reg == '0)
                        begin
                            act_next   = ACT_INS;
                            state_next = ST_COMMIT;
                        end
                        else
                        begin
                            state_next = ST_PROBE;
                        end
                    end
                end
            end
            ST_PROBE:
            begin
                // token sits on the newest entry
                state_next = ST_COMMIT;
                if (msg_type_reg == T_NOTE_OFF)
                begin
                    if (any_head)
                    begin
                        act_next = any_hit ? ACT_UPD : ACT_INS;
                    end
                    else if (count_reg == CNT_W'(1))
                    begin
                        act_next = ACT_INS;
                    end
                    else
                    begin
                        // walk older entries for a note-on of this note
                        ctl.tok_shift = 1'b1;
                        idx_next      = idx_reg + IDX_W'(1);
                        state_next    = ST_SCAN;
                    end
                end
                else
                begin
                    act_next = any_cond ? ACT_UPD : ACT_INS;
                end
            end
            ST_SCAN:
            begin
                if (any_hit)
                begin
                    act_next   = ACT_UPD;
                    state_next = ST_COMMIT;
                end
                else if (last_idx)
                begin
                    act_next   = ACT_INS;
                    state_next = ST_COMMIT;
                end
                else
                begin
                    ctl.tok_shift = 1'b1;
                    idx_next      = idx_reg + IDX_W'(1);
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    ctl.tok_clr    = 1'b1;
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    otype_next     = msg_type_reg;
                    ochan_next     = chan_reg;
                    od1_next       = d1_reg;
                    od2_next       = d2_reg;
                    ostamp_next    = timer_reg;
                    otime_next     = 32'd0;
                    unique case (act_reg)
                        ACT_INS:
                        begin
                            ctl.ins     = 1'b1;
                            count_next  = count_ins;
                            kind_next   = RK_INSERT;
                            slot_next   = 4'd0;
                            ocount_next = 4'(count_ins);
                        end
                        ACT_UPD:
                        begin
                            // token still marks the matched cell
                            ctl.upd     = 1'b1;
                            kind_next   = RK_UPDATE;
                            slot_next   = 4'(idx_reg);
                            ocount_next = 4'(count_reg);
                        end
                        default:
                        begin
                            kind_next   = RK_MARK;
                            slot_next   = 4'd0;
                            otype_next  = 4'd0;
                            ochan_next  = 4'd0;
                            od1_next    = 8'd0;
                            od2_next    = 8'd0;
                            ostamp_next = 32'd0;
                            otime_next  = mark_time_reg;
                            ocount_next = 4'(count_reg);
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            act_reg       <= ACT_INS;
            idx_reg       <= '0;
            count_reg     <= '0;
            timer_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            timer_reg     <= timer_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // message and result payload
    always_ff @(posedge clk)
    begin
        mark_time_reg <= mark_time_next;
        msg_type_reg  <= msg_type_next;
        chan_reg      <= chan_next;
        d1_reg        <= d1_next;
        d2_reg        <= d2_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        otype_reg     <= otype_next;
        ochan_reg     <= ochan_next;
        od1_reg       <= od1_next;
        od2_reg       <= od2_next;
        ostamp_reg    <= ostamp_next;
        otime_reg     <= otime_next;
        ocount_reg    <= ocount_next;
    end

    assign out_valid   = out_valid_reg;
    assign report_kind = kind_reg;
    assign slot        = slot_reg;
    assign msg_type    = otype_reg;
    assign channel     = ochan_reg;
    assign first_data  = od1_reg;
    assign second_data = od2_reg;
    assign stamp       = ostamp_reg;
    assign clock_time  = otime_reg;
    assign entry_count = ocount_reg;

    // search token is never duplicated along the chain
    `MET_ASSERT_HOLDS(a_tok_single, $onehot0(tok_vec), "more than one search token")
    // no stale token left over once the sequencer is back at rest
    `MET_ASSERT_IMPLIES(a_tok_idle, state_reg == ST_IDLE, tok_vec == '0,
        "token left in chain while idle")
    // a search in progress always has its token inside the list
    `MET_ASSERT_IMPLIES(a_tok_scan, state_reg == ST_SCAN, tok_vec != '0,
        "search lost its token")
    // list never grows past its capacity
    `MET_ASSERT_HOLDS(a_count_max, count_reg <= CNT_W'(MAX_EVENTS), "entry count overflow")
    // a commit with room in the output register completes and shows a result
    `MET_ASSERT_NEXT(a_commit_done, state_reg == ST_COMMIT && out_free,
        state_reg == ST_IDLE && out_valid_reg, "commit did not complete")

endmodule

`default_nettype wire

[rtl/met_parser.sv]
// midi byte parser, clock byte divider and clock mark register
`default_nettype none

module met_parser
    import met_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata,
    input  wire logic        accept,
    input  wire logic        op,
    input  wire logic [7:0]  midi_byte,
    output met_parse_t       result
);

    localparam logic [1:0] PH_STATUS = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    localparam logic [7:0] MIDI_CLOCK = 8'hF8;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] first_reg, first_next;
    logic [4:0] clk_cnt_reg, clk_cnt_next;
    logic [4:0] cpm_reg;
    logic [4:0] cnt_inc;
    logic [3:0] held_type;

    assign held_type = status_reg[7:4];
    assign cnt_inc   = clk_cnt_reg + 5'd1;

    always_comb
    begin
        result       = '0;
        phase_next   = phase_reg;
        status_next  = status_reg;
        first_next   = first_reg;
        clk_cnt_next = clk_cnt_reg;
        if (op)
        begin
            result.tick = 1'b1;
        end
        else if (midi_byte == MIDI_CLOCK)
        begin
            if (cnt_inc == cpm_reg)
            begin
                result.mark  = 1'b1;
                clk_cnt_next = 5'd0;
            end
            else
            begin
                clk_cnt_next = cnt_inc;
            end
        end
        else if (midi_byte[7:4] == 4'hF)
        begin
            // other system byte aborts any partial message
            phase_next = PH_STATUS;
        end
        else if (midi_byte[7])
        begin
            status_next = midi_byte;
            phase_next  = PH_FIRST;
        end
        else
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    if (held_type == T_PROGRAM || held_type == T_CHAN_PRESS)
                    begin
                        result.msg_done = 1'b1;
                        result.d1       = midi_byte;
                        phase_next      = PH_STATUS;
                    end
                    else
                    begin
                        first_next = midi_byte;
                        phase_next = PH_SECOND;
                    end
                end
                PH_SECOND:
                begin
                    result.msg_done = 1'b1;
                    result.d1       = first_reg;
                    result.d2       = midi_byte;
                    phase_next      = PH_STATUS;
                end
                default:
                begin
                    // data with no status is dropped
                    phase_next = PH_STATUS;
                end
            endcase
        end
        result.msg_type = held_type;
        result.chan     = status_reg[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_STATUS;
            status_reg  <= 8'd0;
            first_reg   <= 8'd0;
            clk_cnt_reg <= 5'd0;
            cpm_reg     <= MET_CPM_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                status_reg  <= status_next;
                first_reg   <= first_next;
                clk_cnt_reg <= clk_cnt_next;
            end
            if (cfg_we)
            begin
                cpm_reg <= cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/met_cell.sv]
// one event list cell: entry storage, search token and match flags
`default_nettype none

module met_cell
    import met_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire met_cell_ctl_t ctl,
    input  wire met_entry_t    key,
    input  wire met_entry_t    entry_in,
    input  wire logic          tok_in,
    output met_entry_t         entry_out,
    output logic               tok_out,
    output met_flags_t         flags
);

    met_entry_t entry_reg;
    logic       tok_reg;
    logic       d1_eq, chan_eq, is_on, type_ok, data_ok;

    assign entry_out = entry_reg;
    assign tok_out   = tok_reg;

    assign d1_eq   = entry_reg.d1 == key.d1;
    assign chan_eq = entry_reg.chan == key.chan;
    assign is_on   = entry_reg.msg_type == T_NOTE_ON;
    assign type_ok = (key.msg_type == entry_reg.msg_type) ||
                     (key.msg_type == T_NOTE_OFF && is_on);
    assign data_ok = ((key.msg_type == T_NOTE_OFF || key.msg_type == T_CTRL) && d1_eq) ||
                     key.msg_type == T_BEND || key.msg_type == T_CHAN_PRESS;

    assign flags.head = tok_reg && is_on && d1_eq;
    assign flags.hit  = tok_reg && is_on && d1_eq && chan_eq;
    assign flags.cond = tok_reg && chan_eq && type_ok && data_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else if (ctl.tok_clr)
        begin
            tok_reg <= 1'b0;
        end
        else if (ctl.tok_shift)
        begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ins)
        begin
            entry_reg <= entry_in;
        end
        else if (ctl.upd && tok_reg)
        begin
            entry_reg <= key;
        end
    end

endmodule

`default_nettype wire
